>>> hdl/snaw_pkg.sv
`default_nettype none

package snaw_pkg;

   localparam int DIMS            = 4;
   localparam int DIM_BITS        = $clog2(DIMS);
   localparam int OFFSET_BITS     = 24;
   localparam int SIZE_BITS       = 16;
   localparam int PROD_BITS       = OFFSET_BITS + SIZE_BITS;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 24;
   localparam int CSR_SIZE_BASE   = 0;
   localparam int CSR_STRIDE_BASE = 4;

   typedef logic [SIZE_BITS-1:0]   size_type;
   typedef logic [OFFSET_BITS-1:0] offset_type;

   // Effective sizes (never zero), strides and the offset change caused by a carry
   // out of each dimension, which is stride * (1 - size) modulo 2^OFFSET_BITS.
   typedef struct packed {
      size_type   [DIMS-1:0] size;
      offset_type [DIMS-1:0] stride;
      offset_type [DIMS-1:0] delta;
   } cfg_type;

   typedef struct packed {
      offset_type source_offset;
      offset_type dest_offset;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

>>> hdl/snaw_cfg.sv
`default_nettype none

module snaw_cfg (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [snaw_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [snaw_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output snaw_pkg::cfg_type                         cfg
);
   import snaw_pkg::*;

   size_type   [DIMS-1:0] size_ff;
   offset_type [DIMS-1:0] stride_ff;
   offset_type [DIMS-1:0] delta_ff;

   logic                         is_stride;
   logic [CSR_INDEX_BITS-1:0]    dim_index;
   logic [DIM_BITS-1:0]          dim;
   size_type                     new_size;
   size_type                     mul_size;
   offset_type                   mul_stride;
   logic [PROD_BITS-1:0]         product;
   offset_type                   delta_in;

   // The carry delta is recomputed together with every write, so it is never stale.
   always_comb begin
      is_stride  = csr_index >= CSR_INDEX_BITS'(CSR_STRIDE_BASE);
      dim_index  = is_stride ? csr_index - CSR_INDEX_BITS'(CSR_STRIDE_BASE)
                             : csr_index - CSR_INDEX_BITS'(CSR_SIZE_BASE);
      dim        = dim_index[DIM_BITS-1:0];
      new_size   = (csr_data[SIZE_BITS-1:0] == '0) ? SIZE_BITS'(1) : csr_data[SIZE_BITS-1:0];
      mul_size   = is_stride ? size_ff[dim] : new_size;
      mul_stride = is_stride ? offset_type'(csr_data) : stride_ff[dim];
      product    = PROD_BITS'(mul_stride) * PROD_BITS'(mul_size);
      delta_in   = mul_stride - product[OFFSET_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < DIMS; d++) begin
            size_ff[d]   <= SIZE_BITS'(1);
            stride_ff[d] <= OFFSET_BITS'(1);
            delta_ff[d]  <= '0;
         end
      end else if (csr_write_enable) begin
         if (is_stride) begin
            stride_ff[dim] <= offset_type'(csr_data);
         end else begin
            size_ff[dim] <= new_size;
         end
         delta_ff[dim] <= delta_in;
      end
   end

   assign cfg = '{size: size_ff, stride: stride_ff, delta: delta_ff};

endmodule

`default_nettype wire

>>> hdl/snaw_step.sv
`default_nettype none

module snaw_step (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire snaw_pkg::cfg_type cfg,
   input  wire logic           advance,
   input  wire logic           restart,
   output snaw_pkg::result_type result
);
   import snaw_pkg::*;

   size_type [DIMS-1:0] pc_ff;
   size_type [DIMS-1:0] pc_in;
   offset_type          offset_ff;
   offset_type          offset_in;
   offset_type          count_ff;
   offset_type          count_in;

   size_type [DIMS-1:0] pc_cur;
   offset_type          offset_cur;
   offset_type          count_cur;
   logic     [DIMS-1:0] at_final;
   logic                last;

   always_comb begin
      logic       carry;
      offset_type sum;
      carry      = 1'b1;
      offset_cur = restart ? '0 : offset_ff;
      count_cur  = restart ? '0 : count_ff;
      for (int d = 0; d < DIMS; d++) begin
         pc_cur[d]   = restart ? '0 : pc_ff[d];
         at_final[d] = ({1'b0, pc_cur[d]} + (SIZE_BITS+1)'(1)) >= {1'b0, cfg.size[d]};
      end
      last = &at_final;

      // Innermost dimension first: final counters wrap and carry, the first
      // counter that is not final steps on and absorbs the carry.
      sum = offset_cur;
      for (int d = DIMS - 1; d >= 0; d--) begin
         pc_in[d] = pc_cur[d];
         if (carry) begin
            if (at_final[d]) begin
               pc_in[d] = '0;
               sum      = sum + cfg.delta[d];
            end else begin
               pc_in[d] = pc_cur[d] + SIZE_BITS'(1);
               sum      = sum + cfg.stride[d];
               carry    = 1'b0;
            end
         end
      end
      offset_in = sum;
      count_in  = count_cur + OFFSET_BITS'(1);

      if (last) begin
         pc_in     = '0;
         offset_in = '0;
         count_in  = '0;
      end

      result.source_offset = offset_cur;
      result.dest_offset   = count_cur;
      result.last          = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         offset_ff <= '0;
         count_ff  <= '0;
      end else if (advance) begin
         pc_ff     <= pc_in;
         offset_ff <= offset_in;
         count_ff  <= count_in;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && last) |=> (pc_ff == '0 && offset_ff == '0 && count_ff == '0))
      else $error("walk state not cleared after the last item");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      (advance && !last) |=> (count_ff == OFFSET_BITS'($past(count_cur) + OFFSET_BITS'(1))))
      else $error("destination index did not advance by one");

   a_inner_moves: assert property (@(posedge clock) disable iff (reset)
      (advance && !last) |=>
         (pc_ff[DIMS-1] == SIZE_BITS'($past(pc_cur[DIMS-1]) + SIZE_BITS'(1)) ||
          pc_ff[DIMS-1] == '0))
      else $error("innermost counter neither stepped nor wrapped");

endmodule

`default_nettype wire

>>> hdl/strided_nd_address_walk.sv
`default_nettype none

// Address generator for a gather copy of a strided four-dimensional view into a
// dense buffer. Each accepted item asks for the next element and yields one result
// with its source offset, its dense destination index and a last flag; an item with
// restart set begins a fresh walk from element zero, and the walk restarts by itself
// after the last element. One item is accepted every cycle unless req_stall is high,
// with its result on the following cycle; the carry update is combinational. Sizes
// of zero act as one, and all offsets wrap modulo 2^24. Configuration writes take
// effect on the following cycle and belong between walks.
module strided_nd_address_walk (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic                                 req_restart,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic [snaw_pkg::OFFSET_BITS-1:0]    rsp_source_offset,
   output      logic [snaw_pkg::OFFSET_BITS-1:0]    rsp_dest_offset,
   output      logic                                 rsp_last,
   input  wire logic                                 csr_write_enable,
   input  wire logic [snaw_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [snaw_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import snaw_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;

   snaw_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   snaw_step u_step (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (accept),
      .restart (req_restart),
      .result  (result)
   );

   // A new item may enter whenever the result register is empty or being taken.
   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_source_offset = rsp_ff.source_offset;
   assign rsp_dest_offset   = rsp_ff.dest_offset;
   assign rsp_last          = rsp_ff.last;

endmodule

`default_nettype wire

>>> verif/strided_nd_address_walk_test.sv
module strided_nd_address_walk_test;
   timeunit 1ns;
   timeprecision 1ps;

   import snaw_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 950;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic                      req_restart      = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   logic [OFFSET_BITS-1:0]    rsp_source_offset;
   logic [OFFSET_BITS-1:0]    rsp_dest_offset;
   logic                      rsp_last;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data         = '0;

   // Own copy of the walk: registers, per-dimension positions, offset and count.
   size_type   walk_size   [DIMS];
   offset_type walk_stride [DIMS];
   size_type   walk_pos    [DIMS];
   offset_type walk_offset;
   offset_type walk_count;

   bit                       restart_pending [$];
   result_type               element_expect  [$];
   logic [CSR_DATA_BITS-1:0] reg_value [2*DIMS];
   bit                       write_mask [2*DIMS];
   bit                       steady      = 1'b0;
   int unsigned              send_wait   = 0;
   int unsigned              rsp_wait    = 0;
   int unsigned              failures    = 0;
   int unsigned              cycle_count = 0;

   strided_nd_address_walk DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_source_offset (rsp_source_offset),
      .rsp_dest_offset   (rsp_dest_offset),
      .rsp_last          (rsp_last),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #2 clock = ~clock;

   function automatic void restart_walk();
      for (int d = 0; d < DIMS; d++) walk_pos[d] = '0;
      walk_offset = '0;
      walk_count  = '0;
   endfunction

   // A size register of zero behaves as a dimension of one element.
   function automatic logic [SIZE_BITS:0] span_of(input int d);
      return (walk_size[d] == '0) ? (SIZE_BITS+1)'(1) : {1'b0, walk_size[d]};
   endfunction

   function automatic result_type next_element(input logic restart);
      result_type          element;
      logic                final_pos;
      logic                carry;
      logic [SIZE_BITS:0]  span;
      if (restart) restart_walk();
      final_pos = 1'b1;
      for (int d = 0; d < DIMS; d++) begin
         if ({1'b0, walk_pos[d]} + 1 < span_of(d)) final_pos = 1'b0;
      end
      element.source_offset = walk_offset;
      element.dest_offset   = walk_count;
      element.last          = final_pos;
      if (final_pos) begin
         restart_walk();
      end else begin
         walk_count = walk_count + 1'b1;
         carry = 1'b1;
         // Innermost first; a counter at or beyond its size wraps to zero and
         // takes back stride times size from the offset.
         for (int d = DIMS - 1; d >= 0 && carry; d--) begin
            span = span_of(d);
            walk_pos[d] = walk_pos[d] + 1'b1;
            walk_offset = walk_offset + walk_stride[d];
            if ({1'b0, walk_pos[d]} < span && walk_pos[d] != '0) begin
               carry = 1'b0;
            end else begin
               walk_pos[d] = '0;
               walk_offset = walk_offset - offset_type'(walk_stride[d] * span);
            end
         end
      end
      return element;
   endfunction

   function automatic void note_field(input string field, input logic [OFFSET_BITS-1:0] want,
                                      input logic [OFFSET_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : drive_requests
      result_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted = next_element(req_restart);
            element_expect.push_back(predicted);
         end
         if (!req_valid || !req_stall) begin
            if (send_wait == 0 && restart_pending.size() != 0) begin
               req_valid   <= 1'b1;
               req_restart <= restart_pending.pop_front();
               send_wait   <= steady ? 0 : $urandom_range(0, 9);
            end else begin
               req_valid <= 1'b0;
               if (send_wait != 0) send_wait <= send_wait - 1;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      result_type  want;
      int unsigned hold;
      hold = rsp_wait;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (element_expect.size() == 0) begin
            $display("%0t: unexpected item expected none actual %h %h %b", $time,
                     rsp_source_offset, rsp_dest_offset, rsp_last);
            failures++;
         end else begin
            want = element_expect.pop_front();
            note_field("source_offset", want.source_offset, rsp_source_offset);
            note_field("dest_offset", want.dest_offset, rsp_dest_offset);
            note_field("last", OFFSET_BITS'(want.last), OFFSET_BITS'(rsp_last));
         end
         hold = steady ? 0 : $urandom_range(0, 9);
      end
      if (hold != 0) begin
         rsp_stall <= 1'b1;
         rsp_wait  <= hold - 1;
      end else begin
         rsp_stall <= 1'b0;
         rsp_wait  <= 0;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Returns once the sender is empty and every predicted item has come back.
   task automatic drain();
      while (restart_pending.size() != 0 || req_valid || element_expect.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic commit_config();
      for (int r = 0; r < 2*DIMS; r++) begin
         if (write_mask[r]) begin
            @(posedge clock);
            csr_write_enable <= 1'b1;
            csr_index        <= CSR_INDEX_BITS'(r);
            csr_data         <= reg_value[r];
            if (r < CSR_STRIDE_BASE) walk_size[r - CSR_SIZE_BASE] = reg_value[r][SIZE_BITS-1:0];
            else walk_stride[r - CSR_STRIDE_BASE] = reg_value[r];
         end
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : run_phases
      int unsigned queued;
      int unsigned count;
      for (int d = 0; d < DIMS; d++) begin
         walk_size[d]   = 1;
         walk_stride[d] = 1;
      end
      restart_walk();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // With every size at one, each item is the whole walk.
      restart_pending.push_back(1'b0);
      restart_pending.push_back(1'b1);
      restart_pending.push_back(1'b0);
      drain();

      // Mixed sizes, a zero size and the largest stride; the walk is left mid-pass.
      reg_value[CSR_SIZE_BASE + 0]   = 2;
      reg_value[CSR_SIZE_BASE + 1]   = 3;
      reg_value[CSR_SIZE_BASE + 2]   = 0;
      reg_value[CSR_SIZE_BASE + 3]   = 4;
      reg_value[CSR_STRIDE_BASE + 0] = 24'hFFFFFF;
      reg_value[CSR_STRIDE_BASE + 1] = 5;
      reg_value[CSR_STRIDE_BASE + 2] = 24'h123456;
      reg_value[CSR_STRIDE_BASE + 3] = 24'h000100;
      for (int r = 0; r < 2*DIMS; r++) write_mask[r] = 1'b1;
      commit_config();
      restart_pending.push_back(1'b1);
      repeat (9) restart_pending.push_back(1'b0);
      drain();

      // Changing the sizes mid-pass leaves a counter beyond its new final position.
      reg_value[CSR_SIZE_BASE + 0]   = 16'hFFFF;
      reg_value[CSR_SIZE_BASE + 1]   = 2;
      reg_value[CSR_SIZE_BASE + 2]   = 16'hFFFF;
      reg_value[CSR_SIZE_BASE + 3]   = 16'hFFFF;
      reg_value[CSR_STRIDE_BASE + 0] = 0;
      reg_value[CSR_STRIDE_BASE + 1] = 24'hFFFFFF;
      reg_value[CSR_STRIDE_BASE + 2] = 24'hFFFFFF;
      reg_value[CSR_STRIDE_BASE + 3] = 24'hABCDEF;
      commit_config();
      repeat (6) restart_pending.push_back(1'b0);
      restart_pending.push_back(1'b1);
      repeat (2) restart_pending.push_back(1'b0);
      drain();

      queued = 0;
      while (queued < RANDOM_ITEMS) begin
         for (int d = 0; d < DIMS; d++) begin
            case ($urandom_range(0, 15))
               0:       reg_value[CSR_SIZE_BASE + d] = 0;
               1:       reg_value[CSR_SIZE_BASE + d] = 16'hFFFF;
               2:       reg_value[CSR_SIZE_BASE + d] =
                           CSR_DATA_BITS'($urandom_range(0, 16'hFFFF));
               default: reg_value[CSR_SIZE_BASE + d] = CSR_DATA_BITS'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 7))
               0:       reg_value[CSR_STRIDE_BASE + d] = 0;
               1:       reg_value[CSR_STRIDE_BASE + d] = 24'hFFFFFF;
               2:       reg_value[CSR_STRIDE_BASE + d] = CSR_DATA_BITS'($urandom_range(1, 8));
               default: reg_value[CSR_STRIDE_BASE + d] =
                           CSR_DATA_BITS'($urandom_range(0, 24'hFFFFFF));
            endcase
         end
         for (int r = 0; r < 2*DIMS; r++) write_mask[r] = 1'($urandom_range(0, 1));
         commit_config();
         steady = ($urandom_range(0, 3) == 0);
         count = $urandom_range(20, 120);
         // Mostly uninterrupted walks; a rare restart breaks one off.
         restart_pending.push_back(1'($urandom_range(0, 1)));
         for (int i = 1; i < count; i++) restart_pending.push_back($urandom_range(0, 31) == 0);
         queued += count;
         drain();
         steady = 1'b0;
      end

      drain();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/snaw_pkg.sv
hdl/snaw_cfg.sv
hdl/snaw_step.sv
hdl/strided_nd_address_walk.sv
verif/strided_nd_address_walk_test.sv
